// ----- design/ptpm_pkg.sv -----
// Package for the pedal torque plausibility monitor.
// Holds shared widths, register indexes, controller states and the
// command and status structs. No dependencies.
`default_nettype none

package ptpm_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int DIV_STEPS  = LIMIT_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam int BRAKE_ACTIVE_LEVEL_DEF = 1000;
    localparam int ADC_BITS_DEF           = 12;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PEDAL_ONE_START   = 3'd0,
        REG_PEDAL_ONE_END     = 3'd1,
        REG_PEDAL_TWO_START   = 3'd2,
        REG_PEDAL_TWO_END     = 3'd3,
        REG_PEDAL_ONE_FLOOR   = 3'd4,
        REG_PEDAL_ONE_CEILING = 3'd5,
        REG_PEDAL_TWO_FLOOR   = 3'd6,
        REG_PEDAL_TWO_CEILING = 3'd7
    } cfg_reg_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic start_mul;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- design/ptpm_ctrl.sv -----
// Controller state machine of the pedal torque plausibility monitor.
// Sequences sample capture, multiply, divide and result load.
// Depends on ptpm_pkg.
`default_nettype none

module ptpm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ptpm_pkg::dp_status_t status,
    output ptpm_pkg::dp_cmd_t         cmd
);

    ptpm_pkg::state_t state_reg;
    ptpm_pkg::state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptpm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptpm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ptpm_pkg::ST_MUL;
                end
            end
            ptpm_pkg::ST_MUL:
            begin
                state_next = ptpm_pkg::ST_DIV;
            end
            ptpm_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ptpm_pkg::ST_FINISH;
                end
            end
            ptpm_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ptpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptpm_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ptpm_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ptpm_pkg::ST_MUL:
            begin
                cmd.start_mul = 1'b1;
            end
            ptpm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ptpm_pkg::ST_FINISH:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/ptpm_dp.sv -----
// Datapath of the pedal torque plausibility monitor: configuration
// registers, sample registers, torque multiplier, restoring divider,
// plausibility checks, fault latch and output register. Depends on ptpm_pkg.
`default_nettype none

module ptpm_dp #(
    parameter int BRAKE_ACTIVE_LEVEL = ptpm_pkg::BRAKE_ACTIVE_LEVEL_DEF,
    parameter int ADC_BITS           = ptpm_pkg::ADC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ptpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ptpm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [ptpm_pkg::SAMPLE_W-1:0]     accel_one_sample,
    input  wire logic [ptpm_pkg::SAMPLE_W-1:0]     accel_two_sample,
    input  wire logic [ptpm_pkg::SAMPLE_W-1:0]     brake_sample,
    input  wire logic [ptpm_pkg::LIMIT_W-1:0]      torque_limit,
    input  wire ptpm_pkg::dp_cmd_t                 cmd,
    output ptpm_pkg::dp_status_t                   status,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [ptpm_pkg::LIMIT_W-1:0]           torque_request,
    output logic                                   brake_engaged,
    output logic                                   accel_plausible,
    output logic                                   brake_plausible,
    output logic                                   pedals_consistent,
    output logic                                   fault_latched
);

    localparam int SW   = ptpm_pkg::SAMPLE_W;
    localparam int LW   = ptpm_pkg::LIMIT_W;
    localparam int PW   = SW + LW;
    localparam int MW   = SW + 2;
    localparam int CW   = ptpm_pkg::CNT_W;

    localparam logic [SW-1:0] SAMPLE_MASK =
        (ADC_BITS >= SW) ? {SW{1'b1}} : SW'((1 << ADC_BITS) - 1);
    localparam logic [SW-1:0] BRAKE_LEVEL = SW'(BRAKE_ACTIVE_LEVEL);
    localparam logic [SW-1:0] BRAKE_LOW   = SW'(200);
    localparam logic [SW-1:0] BRAKE_HIGH  = SW'(4000);
    localparam logic [17:0]   RECIP_FIVE  = 18'd205;

    // Travel mark: start + (end - start) / 4 or / 20, truncating toward zero.
    // The twentieth is (|span| / 4) / 5, with / 5 as a multiply by 205 / 1024.
    function automatic logic signed [MW-1:0] travel_mark(
        input logic [SW-1:0] start,
        input logic [SW-1:0] stop,
        input logic          twentieth
    );
        logic signed [SW:0]   span;
        logic [SW-1:0]        mag;
        logic [SW-3:0]        q4;
        logic [17:0]          prod;
        logic [SW-3:0]        part;
        logic signed [MW-1:0] offs;
        span = $signed({1'b0, stop}) - $signed({1'b0, start});
        mag  = span[SW] ? SW'(-span) : span[SW-1:0];
        q4   = mag[SW-1:2];
        prod = 18'(q4) * RECIP_FIVE;
        part = twentieth ? (SW-2)'(prod[17:10]) : q4;
        offs = $signed({4'b0, part});
        if (span[SW])
        begin
            offs = -offs;
        end
        return $signed({2'b0, start}) + offs;
    endfunction

    // Configuration registers
    logic [SW-1:0] p1_start_reg, p1_end_reg, p2_start_reg, p2_end_reg;
    logic [SW-1:0] p1_floor_reg, p1_ceil_reg, p2_floor_reg, p2_ceil_reg;

    // Sample registers
    logic [SW-1:0] a1_reg, a2_reg, br_reg;
    logic [LW-1:0] lim_reg;

    // Divider and map registers
    logic [SW-1:0]        span_reg;
    logic [SW-1:0]        rem_reg;
    logic [LW-1:0]        shq_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 zero_reg;
    logic                 clamp_reg;
    logic signed [MW-1:0] q1_reg, q2_reg, f1_reg, f2_reg;

    // Fault latch and output register
    logic          fault_reg;
    logic          fault_next;
    logic          out_valid_reg;
    logic [LW-1:0] torque_reg;
    logic          brake_on_reg, accel_ok_reg, brake_ok_reg, consistent_reg;

    // Combinational helpers
    logic [SW-1:0] diff;
    logic [SW-1:0] span_now;
    logic [PW-1:0] product;
    logic [SW:0]   trial;
    logic          trial_ge;
    logic [LW-1:0] torque_now;
    logic          brake_on, accel_ok, brake_ok, pressed, released, consistent;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_start_reg <= '0;
            p1_end_reg   <= '1;
            p2_start_reg <= '0;
            p2_end_reg   <= '1;
            p1_floor_reg <= '0;
            p1_ceil_reg  <= '1;
            p2_floor_reg <= '0;
            p2_ceil_reg  <= '1;
        end
        else if (cfg_we)
        begin
            case (ptpm_pkg::cfg_reg_t'(cfg_index))
                ptpm_pkg::REG_PEDAL_ONE_START:   p1_start_reg <= cfg_data;
                ptpm_pkg::REG_PEDAL_ONE_END:     p1_end_reg   <= cfg_data;
                ptpm_pkg::REG_PEDAL_TWO_START:   p2_start_reg <= cfg_data;
                ptpm_pkg::REG_PEDAL_TWO_END:     p2_end_reg   <= cfg_data;
                ptpm_pkg::REG_PEDAL_ONE_FLOOR:   p1_floor_reg <= cfg_data;
                ptpm_pkg::REG_PEDAL_ONE_CEILING: p1_ceil_reg  <= cfg_data;
                ptpm_pkg::REG_PEDAL_TWO_FLOOR:   p2_floor_reg <= cfg_data;
                ptpm_pkg::REG_PEDAL_TWO_CEILING: p2_ceil_reg  <= cfg_data;
                default:                         p1_start_reg <= p1_start_reg;
            endcase
        end
    end

    // Capture the sample set, dropping bits above the converter width
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a1_reg  <= accel_one_sample & SAMPLE_MASK;
            a2_reg  <= accel_two_sample & SAMPLE_MASK;
            br_reg  <= brake_sample & SAMPLE_MASK;
            lim_reg <= torque_limit;
        end
    end

    // Scale the pedal offset by the limit; below span the quotient fits LW bits
    assign diff     = a1_reg - p1_start_reg;
    assign span_now = p1_end_reg - p1_start_reg;
    assign product  = PW'(diff) * PW'(lim_reg);

    // One restoring divider step
    assign trial    = {rem_reg, shq_reg[LW-1]};
    assign trial_ge = trial >= {1'b0, span_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.start_mul)
        begin
            span_reg  <= span_now;
            rem_reg   <= product[PW-1:LW];
            shq_reg   <= product[LW-1:0];
            zero_reg  <= (p1_end_reg <= p1_start_reg) || (a1_reg <= p1_start_reg);
            clamp_reg <= diff >= span_now;
            q1_reg    <= travel_mark(p1_start_reg, p1_end_reg, 1'b0);
            q2_reg    <= travel_mark(p2_start_reg, p2_end_reg, 1'b0);
            f1_reg    <= travel_mark(p1_start_reg, p1_end_reg, 1'b1);
            f2_reg    <= travel_mark(p2_start_reg, p2_end_reg, 1'b1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? SW'(trial - {1'b0, span_reg}) : trial[SW-1:0];
            shq_reg <= {shq_reg[LW-2:0], trial_ge};
        end
    end

    // Count divider steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.start_mul)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    assign status.div_last = cnt_reg == CW'(ptpm_pkg::DIV_STEPS - 1);
    assign status.out_free = !out_valid_reg || out_ready;

    // Select torque and evaluate the checks
    always_comb
    begin
        if (zero_reg)
        begin
            torque_now = '0;
        end
        else if (clamp_reg)
        begin
            torque_now = lim_reg;
        end
        else
        begin
            torque_now = shq_reg;
        end
        brake_on   = br_reg >= BRAKE_LEVEL;
        accel_ok   = (a1_reg >= p1_floor_reg) && (a1_reg <= p1_ceil_reg) &&
                     (a2_reg >= p2_floor_reg) && (a2_reg <= p2_ceil_reg);
        brake_ok   = (br_reg >= BRAKE_LOW) && (br_reg <= BRAKE_HIGH);
        pressed    = ($signed({2'b0, a1_reg}) > q1_reg) ||
                     ($signed({2'b0, a2_reg}) > q2_reg);
        released   = ($signed({2'b0, a1_reg}) < f1_reg) &&
                     ($signed({2'b0, a2_reg}) < f2_reg);
        consistent = !(pressed && brake_on);
        fault_next = fault_reg;
        if (consistent && released)
        begin
            fault_next = 1'b0;
        end
        if (!consistent || !brake_ok || !accel_ok)
        begin
            fault_next = 1'b1;
        end
    end

    // Update the fault latch and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            fault_reg     <= fault_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            torque_reg     <= torque_now;
            brake_on_reg   <= brake_on;
            accel_ok_reg   <= accel_ok;
            brake_ok_reg   <= brake_ok;
            consistent_reg <= consistent;
        end
    end

    assign out_valid         = out_valid_reg;
    assign torque_request    = torque_reg;
    assign brake_engaged     = brake_on_reg;
    assign accel_plausible   = accel_ok_reg;
    assign brake_plausible   = brake_ok_reg;
    assign pedals_consistent = consistent_reg;
    assign fault_latched     = fault_reg;

endmodule

`default_nettype wire

// ----- design/pedal_torque_plausibility_monitor.sv -----
// Top level of the pedal torque plausibility monitor.
// Instantiates ptpm_ctrl and ptpm_dp; depends on ptpm_pkg.
//
// Each transfer on the input channel carries one sample set: two accelerator
// readings, a brake reading and a torque limit. The block answers with one
// result: accelerator one mapped linearly from its start..end calibration onto
// 0..limit (truncating, clamped), the brake-engaged flag, the range checks and
// the pedal-versus-brake check, plus a latched fault flag that any failed
// check sets and that clears only when both accelerators sit below five
// percent travel. An item goes from its input transfer through capture, the
// 12 x 15 bit multiply, the one-bit-per-cycle restoring divider and the load
// of the result register, which waits for a free output register, before the
// next input transfer is taken. The result register lets the next sample set
// be taken while a result still waits. Calibration must keep end above start;
// write the configuration registers only while the block is idle.
`default_nettype none

module pedal_torque_plausibility_monitor #(
    parameter int BRAKE_ACTIVE_LEVEL = ptpm_pkg::BRAKE_ACTIVE_LEVEL_DEF,
    parameter int ADC_BITS           = ptpm_pkg::ADC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ptpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ptpm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [ptpm_pkg::SAMPLE_W-1:0]   accel_one_sample,
    input  wire logic [ptpm_pkg::SAMPLE_W-1:0]   accel_two_sample,
    input  wire logic [ptpm_pkg::SAMPLE_W-1:0]   brake_sample,
    input  wire logic [ptpm_pkg::LIMIT_W-1:0]    torque_limit,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [ptpm_pkg::LIMIT_W-1:0]         torque_request,
    output logic                                 brake_engaged,
    output logic                                 accel_plausible,
    output logic                                 brake_plausible,
    output logic                                 pedals_consistent,
    output logic                                 fault_latched
);

    ptpm_pkg::dp_cmd_t    cmd;
    ptpm_pkg::dp_status_t status;

    ptpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ptpm_dp #(
        .BRAKE_ACTIVE_LEVEL (BRAKE_ACTIVE_LEVEL),
        .ADC_BITS           (ADC_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .accel_one_sample  (accel_one_sample),
        .accel_two_sample  (accel_two_sample),
        .brake_sample      (brake_sample),
        .torque_limit      (torque_limit),
        .cmd               (cmd),
        .status            (status),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .torque_request    (torque_request),
        .brake_engaged     (brake_engaged),
        .accel_plausible   (accel_plausible),
        .brake_plausible   (brake_plausible),
        .pedals_consistent (pedals_consistent),
        .fault_latched     (fault_latched)
    );

    // The block is busy right after taking a sample set
    a_busy_after_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input taken again right after a transfer");

    // A clear fault flag means every check of that result passed
    a_fault_covers_checks: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !fault_latched) |->
            (accel_plausible && brake_plausible && pedals_consistent)
    ) else $error("fault flag clear with a failed check");

    // A pedal conflict needs the brake to be engaged
    a_conflict_needs_brake: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !pedals_consistent) |-> brake_engaged
    ) else $error("pedal conflict reported without brake");

    // A result is loaded only into a free output register
    a_load_into_free_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free
    ) else $error("result loaded over a waiting result");

endmodule

`default_nettype wire
